@@ hw/rtl/chm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and the probe step of the compact hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int IndexSlots = 1024;
    localparam int ProbeShift = 5;
    localparam int EntryCap   = (2 * IndexSlots) / 3;
    localparam int SlotW      = $clog2(IndexSlots);
    localparam int EntryW     = 10;
    localparam int SlotDataW  = EntryW + 1;
    localparam int WordW      = 64;

    localparam logic [SlotDataW-1:0] SlotEmpty = {SlotDataW{1'b1}};
    localparam logic [SlotDataW-1:0] SlotDummy = {{(SlotDataW-1){1'b1}}, 1'b0};
    localparam logic [SlotDataW-1:0] SlotCap   = SlotDataW'(EntryCap);
    localparam logic [EntryW-1:0]    EntryCapW = EntryW'(EntryCap);

    typedef logic [1:0] t_op;
    localparam t_op OpLookup = 2'd0;
    localparam t_op OpInsert = 2'd1;
    localparam t_op OpDelete = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status StFound    = 3'd0;
    localparam t_status StInserted = 3'd1;
    localparam t_status StUpdated  = 3'd2;
    localparam t_status StMissing  = 3'd3;
    localparam t_status StFull     = 3'd4;

    typedef struct packed {
        logic             live;
        logic [WordW-1:0] hash;
        logic [WordW-1:0] key;
        logic [WordW-1:0] value;
    } t_entry;

    // next slot: 5*i + perturb + 1, perturb already shifted
    function automatic logic [SlotW-1:0] probe_next(input logic [SlotW-1:0] idx,
                                                   input logic [WordW-1:0] pert);
        return idx + {idx[SlotW-3:0], 2'b00} + pert[SlotW-1:0] + SlotW'(1);
    endfunction

endpackage

@@ hw/rtl/compact_hash_map_engine.sv @@
`timescale 1ns / 1ps
// throughput: one transaction at a time, next accepted the cycle after the result is loaded
// an insert of a new key with no unused entries, while not all entries are live, first compacts
// the entry memory, clears the index and rebuilds it; with all entries live it reports full
// reset: synchronous, active low; a clearing pass over the whole slot memory
// follows, during which no transaction is accepted
// ----------------------------------------------------------------------------
// compact_hash_map_engine
// Hash map with an open-addressed slot index and an insertion-ordered entry
// memory, perturbed probing and compaction when the entry memory is used up.
// ----------------------------------------------------------------------------
module compact_hash_map_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  chm_pkg::t_op          i_operation,
    input  logic [63:0]           i_key_hash,
    input  logic [63:0]           i_key,
    input  logic [63:0]           i_new_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output chm_pkg::t_status      o_status,
    output logic [63:0]           o_found_value,
    output logic [9:0]            o_entry_position,
    output logic [9:0]            o_live_count
);
    import chm_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_SRD   = 15'b000000000000100,
        S_SCHK  = 15'b000000000001000,
        S_EWT   = 15'b000000000010000,
        S_ECHK  = 15'b000000000100000,
        S_ACT   = 15'b000000001000000,
        S_INS   = 15'b000000010000000,
        S_CRD   = 15'b000000100000000,
        S_CWR   = 15'b000001000000000,
        S_RRD   = 15'b000010000000000,
        S_RHASH = 15'b000100000000000,
        S_FRD   = 15'b001000000000000,
        S_FCHK  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    logic [SlotDataW-1:0] slot_mem [IndexSlots];
    t_entry               entry_mem [EntryCap];

    t_state               r_state, n_state;
    logic [SlotW-1:0]     r_idx, n_idx;
    logic [WordW-1:0]     r_pert, n_pert;
    logic [EntryW-1:0]    r_eaddr, n_eaddr;
    logic [SlotW-1:0]     r_cnt, n_cnt;
    logic                 r_rb, n_rb;
    logic [EntryW-1:0]    r_k, n_k;
    logic [EntryW-1:0]    r_j, n_j;
    logic [EntryW-1:0]    r_used, n_used;
    logic [EntryW-1:0]    r_live, n_live;
    logic [EntryW-1:0]    r_unused, n_unused;
    logic                 r_free_ok, n_free_ok;
    logic [SlotW-1:0]     r_free, n_free;
    logic                 r_hit, n_hit;
    logic [SlotW-1:0]     r_hit_slot, n_hit_slot;
    logic                 r_out_valid, n_out_valid;

    t_op                  r_op, n_op;
    logic [WordW-1:0]     r_hash, n_hash;
    logic [WordW-1:0]     r_key, n_key;
    logic [WordW-1:0]     r_val, n_val;
    t_status              r_status, n_status;
    logic [WordW-1:0]     r_fval, n_fval;
    logic [EntryW-1:0]    r_pos, n_pos;
    t_status              r_o_status, n_o_status;
    logic [WordW-1:0]     r_o_fval, n_o_fval;
    logic [EntryW-1:0]    r_o_pos, n_o_pos;
    logic [EntryW-1:0]    r_o_live, n_o_live;

    logic [SlotDataW-1:0] r_slot_q;
    t_entry               r_ent_q;

    logic                 slot_we;
    logic [SlotW-1:0]     slot_wa;
    logic [SlotDataW-1:0] slot_wd;
    logic                 ent_we;
    logic [EntryW-1:0]    ent_wa;
    t_entry               ent_wd;
    logic [WordW-1:0]     pert_sh;

    assign pert_sh = r_pert >> ProbeShift;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_q <= slot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            entry_mem[ent_wa] <= ent_wd;
        end
        r_ent_q <= entry_mem[r_eaddr];
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pert     = r_pert;
        n_eaddr    = r_eaddr;
        n_cnt      = r_cnt;
        n_rb       = r_rb;
        n_k        = r_k;
        n_j        = r_j;
        n_used     = r_used;
        n_live     = r_live;
        n_unused   = r_unused;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_hit      = r_hit;
        n_hit_slot = r_hit_slot;
        n_out_valid = r_out_valid && i_out_stall;
        n_op       = r_op;
        n_hash     = r_hash;
        n_key      = r_key;
        n_val      = r_val;
        n_status   = r_status;
        n_fval     = r_fval;
        n_pos      = r_pos;
        n_o_status = r_o_status;
        n_o_fval   = r_o_fval;
        n_o_pos    = r_o_pos;
        n_o_live   = r_o_live;
        slot_we    = 1'b0;
        slot_wa    = r_idx;
        slot_wd    = SlotEmpty;
        ent_we     = 1'b0;
        ent_wa     = r_eaddr;
        ent_wd     = r_ent_q;

        unique case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_cnt;
                slot_wd = SlotEmpty;
                n_cnt   = r_cnt + SlotW'(1);
                if (r_cnt == SlotW'(IndexSlots - 1)) begin
                    if (!r_rb) begin
                        n_state = S_IDLE;
                    end else if (r_used == '0) begin
                        n_rb    = 1'b0;
                        n_idx   = r_hash[SlotW-1:0];
                        n_pert  = r_hash;
                        n_state = S_FRD;
                    end else begin
                        n_k     = '0;
                        n_eaddr = '0;
                        n_state = S_RRD;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_hash    = i_key_hash;
                    n_key     = i_key;
                    n_val     = i_new_value;
                    n_idx     = i_key_hash[SlotW-1:0];
                    n_pert    = i_key_hash;
                    n_free_ok = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_slot_q == SlotEmpty) begin
                    if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    n_state = S_ACT;
                end else if (r_slot_q >= SlotCap) begin
                    if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    n_pert  = pert_sh;
                    n_idx   = probe_next(r_idx, pert_sh);
                    n_state = S_SRD;
                end else begin
                    n_eaddr = r_slot_q[EntryW-1:0];
                    n_state = S_EWT;
                end
            end
            S_EWT: begin
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (r_ent_q.live && r_ent_q.key == r_key) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_idx;
                    n_state    = S_ACT;
                end else begin
                    n_pert  = pert_sh;
                    n_idx   = probe_next(r_idx, pert_sh);
                    n_state = S_SRD;
                end
            end
            S_ACT: begin
                n_fval   = r_hit ? r_ent_q.value : '0;
                n_pos    = r_hit ? r_eaddr : '0;
                n_status = r_hit ? StFound : StMissing;
                n_state  = S_DONE;
                if (r_op == OpInsert) begin
                    if (r_hit) begin
                        ent_we       = 1'b1;
                        ent_wd.value = r_val;
                        n_status     = StUpdated;
                    end else if (r_unused != '0) begin
                        n_state = S_INS;
                    end else if (r_live < EntryCapW) begin
                        n_k     = '0;
                        n_j     = '0;
                        n_eaddr = '0;
                        n_state = S_CRD;
                    end else begin
                        n_status = StFull;
                    end
                end else if (r_op == OpDelete && r_hit) begin
                    slot_we     = 1'b1;
                    slot_wa     = r_hit_slot;
                    slot_wd     = SlotDummy;
                    ent_we      = 1'b1;
                    ent_wd.live = 1'b0;
                    n_live      = r_live - EntryW'(1);
                end
            end
            S_INS: begin
                slot_we  = 1'b1;
                slot_wa  = r_free;
                slot_wd  = {1'b0, r_used};
                ent_we   = 1'b1;
                ent_wa   = r_used;
                ent_wd   = '{live: 1'b1, hash: r_hash, key: r_key, value: r_val};
                n_used   = r_used + EntryW'(1);
                n_unused = r_unused - EntryW'(1);
                n_live   = r_live + EntryW'(1);
                n_pos    = r_used;
                n_fval   = '0;
                n_status = StInserted;
                n_state  = S_DONE;
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                if (r_ent_q.live) begin
                    ent_we = 1'b1;
                    ent_wa = r_j;
                    n_j    = r_j + EntryW'(1);
                end
                n_k = r_k + EntryW'(1);
                if (r_k + EntryW'(1) == r_used) begin
                    n_used   = r_ent_q.live ? r_j + EntryW'(1) : r_j;
                    n_live   = n_used;
                    n_unused = EntryCapW - n_used;
                    n_cnt    = '0;
                    n_rb     = 1'b1;
                    n_state  = S_CLEAR;
                end else begin
                    n_eaddr = r_k + EntryW'(1);
                    n_state = S_CRD;
                end
            end
            S_RRD: begin
                n_state = S_RHASH;
            end
            S_RHASH: begin
                n_idx   = r_ent_q.hash[SlotW-1:0];
                n_pert  = r_ent_q.hash;
                n_state = S_FRD;
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_slot_q >= SlotCap) begin
                    if (r_rb) begin
                        slot_we = 1'b1;
                        slot_wd = {1'b0, r_k};
                        n_k     = r_k + EntryW'(1);
                        if (r_k + EntryW'(1) == r_used) begin
                            n_rb    = 1'b0;
                            n_idx   = r_hash[SlotW-1:0];
                            n_pert  = r_hash;
                            n_state = S_FRD;
                        end else begin
                            n_eaddr = r_k + EntryW'(1);
                            n_state = S_RRD;
                        end
                    end else begin
                        n_free  = r_idx;
                        n_state = S_INS;
                    end
                end else begin
                    n_pert  = pert_sh;
                    n_idx   = probe_next(r_idx, pert_sh);
                    n_state = S_FRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_fval    = r_fval;
                    n_o_pos     = r_pos;
                    n_o_live    = r_live;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_rb        <= 1'b0;
            r_used      <= '0;
            r_live      <= '0;
            r_unused    <= EntryCapW;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_j         <= '0;
            r_free_ok   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rb        <= n_rb;
            r_used      <= n_used;
            r_live      <= n_live;
            r_unused    <= n_unused;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_j         <= n_j;
            r_free_ok   <= n_free_ok;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pert     <= n_pert;
        r_eaddr    <= n_eaddr;
        r_free     <= n_free;
        r_hit_slot <= n_hit_slot;
        r_op       <= n_op;
        r_hash     <= n_hash;
        r_key      <= n_key;
        r_val      <= n_val;
        r_status   <= n_status;
        r_fval     <= n_fval;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_fval   <= n_o_fval;
        r_o_pos    <= n_o_pos;
        r_o_live   <= n_o_live;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_found_value    = r_o_fval;
    assign o_entry_position = r_o_pos;
    assign o_live_count     = r_o_live;

`ifndef NO_ASSERTIONS
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used + r_unused) == EntryCapW)
        else $error("used and unused entry counts disagree");
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live count above used count");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SRD))
        else $error("accepted transaction did not start a probe");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_o_fval)))
        else $error("stalled result changed");
`endif

endmodule

@@ verif/compact_hash_map_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_hash_map_checker
// Watches both channels of the hash map engine, keeps its own shadow of the
// slot index and entry memory, predicts each response and compares it.
// ----------------------------------------------------------------------------
module compact_hash_map_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  chm_pkg::t_op     i_operation,
    input  logic [63:0]      i_key_hash,
    input  logic [63:0]      i_key,
    input  logic [63:0]      i_new_value,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  chm_pkg::t_status i_status,
    input  logic [63:0]      i_found_value,
    input  logic [9:0]       i_entry_position,
    input  logic [9:0]       i_live_count,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_full_seen,
    output int               o_compactions
);
    import chm_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [63:0] value;
        logic [9:0]  position;
        logic [9:0]  live;
    } t_response;

    localparam int ProbeLimit = 64 + IndexSlots + 1;

    logic [SlotDataW-1:0] shadow_slots [IndexSlots];
    logic [63:0]          shadow_hash  [EntryCap];
    logic [63:0]          shadow_key   [EntryCap];
    logic [63:0]          shadow_value [EntryCap];
    logic                 shadow_live  [EntryCap];
    int                   used_cnt, live_cnt, unused_cnt;
    t_response            response_queue [$];

    initial begin
        o_fail_count  = 0;
        o_full_seen   = 0;
        o_compactions = 0;
        for (int k = 0; k < IndexSlots; k++) shadow_slots[k] = SlotEmpty;
        for (int k = 0; k < EntryCap; k++) shadow_live[k] = 1'b0;
        used_cnt   = 0;
        live_cnt   = 0;
        unused_cnt = EntryCap;
    end

    assign o_pending = response_queue.size();

    function automatic int find_live_key(input logic [63:0] h, input logic [63:0] k,
                                         output int slot);
        logic [SlotW-1:0] idx;
        logic [63:0]      pert;
        logic [SlotDataW-1:0] s;
        idx  = h[SlotW-1:0];
        pert = h;
        slot = 0;
        for (int n = 0; n < ProbeLimit; n++) begin
            s = shadow_slots[idx];
            if (s == SlotEmpty) return -1;
            if (s < SlotCap && shadow_live[s[EntryW-1:0]]
                && shadow_key[s[EntryW-1:0]] == k) begin
                slot = int'(idx);
                return int'(s);
            end
            pert = pert >> ProbeShift;
            idx  = SlotW'(idx * 5 + pert[SlotW-1:0] + 1);
        end
        return -1;
    endfunction

    function automatic int find_free_slot(input logic [63:0] h);
        logic [SlotW-1:0] idx;
        logic [63:0]      pert;
        idx  = h[SlotW-1:0];
        pert = h;
        for (int n = 0; n < ProbeLimit; n++) begin
            if (shadow_slots[idx] >= SlotCap) return int'(idx);
            pert = pert >> ProbeShift;
            idx  = SlotW'(idx * 5 + pert[SlotW-1:0] + 1);
        end
        return -1;
    endfunction

    task automatic compact_entries();
        int j;
        int s;
        j = 0;
        for (int k = 0; k < used_cnt && k < EntryCap; k++) begin
            if (shadow_live[k]) begin
                shadow_hash[j]  = shadow_hash[k];
                shadow_key[j]   = shadow_key[k];
                shadow_value[j] = shadow_value[k];
                shadow_live[j]  = 1'b1;
                j++;
            end
        end
        for (int k = j; k < EntryCap; k++) shadow_live[k] = 1'b0;
        used_cnt   = j;
        live_cnt   = j;
        unused_cnt = EntryCap - j;
        for (int k = 0; k < IndexSlots; k++) shadow_slots[k] = SlotEmpty;
        for (int k = 0; k < j; k++) begin
            s = find_free_slot(shadow_hash[k]);
            if (s >= 0) shadow_slots[s] = SlotDataW'(k);
        end
        o_compactions++;
    endtask

    task automatic predict_response(input t_op op, input logic [63:0] h,
                                    input logic [63:0] k, input logic [63:0] v);
        t_response r;
        int ix;
        int slot;
        int fs;
        r  = '0;
        ix = find_live_key(h, k, slot);
        if (op == OpInsert) begin
            if (ix >= 0) begin
                r.value  = shadow_value[ix];
                shadow_value[ix] = v;
                r.position = 10'(ix);
                r.status = StUpdated;
            end else begin
                if (unused_cnt == 0 && live_cnt < EntryCap) compact_entries();
                fs = (unused_cnt == 0 || used_cnt >= EntryCap) ? -1 : find_free_slot(h);
                if (fs < 0) begin
                    r.status = StFull;
                    o_full_seen++;
                end else begin
                    shadow_slots[fs]       = SlotDataW'(used_cnt);
                    shadow_hash[used_cnt]  = h;
                    shadow_key[used_cnt]   = k;
                    shadow_value[used_cnt] = v;
                    shadow_live[used_cnt]  = 1'b1;
                    r.position = 10'(used_cnt);
                    used_cnt++;
                    unused_cnt--;
                    live_cnt++;
                    r.status = StInserted;
                end
            end
        end else if (op == OpDelete) begin
            if (ix >= 0) begin
                r.value    = shadow_value[ix];
                r.position = 10'(ix);
                shadow_slots[slot] = SlotDummy;
                shadow_live[ix] = 1'b0;
                live_cnt--;
                r.status = StFound;
            end else begin
                r.status = StMissing;
            end
        end else begin
            if (ix >= 0) begin
                r.value    = shadow_value[ix];
                r.position = 10'(ix);
                r.status   = StFound;
            end else begin
                r.status = StMissing;
            end
        end
        r.live = 10'(live_cnt);
        response_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            predict_response(i_operation, i_key_hash, i_key, i_new_value);
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (response_queue.size() == 0) begin
                report_mismatch("unexpected transaction", '0, '0);
            end else begin
                want = response_queue.pop_front();
                if (i_status !== want.status)
                    report_mismatch("status", 64'(i_status), 64'(want.status));
                if (i_found_value !== want.value)
                    report_mismatch("found_value", i_found_value, want.value);
                if (i_entry_position !== want.position)
                    report_mismatch("entry_position", 64'(i_entry_position),
                                    64'(want.position));
                if (i_live_count !== want.live)
                    report_mismatch("live_count", 64'(i_live_count), 64'(want.live));
            end
        end
    end

endmodule

@@ verif/compact_hash_map_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_hash_map_engine_tb
// Drives lookups, inserts, updates and deletes into the hash map engine with
// random gaps and stalls, fills the table to force compaction and full
// responses, and leaves all checking to the companion checker.
// ----------------------------------------------------------------------------
module compact_hash_map_engine_tb;
    import chm_pkg::*;

    localparam int RandomItems = 530;
    localparam int IdleLimit   = 50000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_op         i_operation = OpLookup;
    logic [63:0] i_key_hash = '0;
    logic [63:0] i_key = '0;
    logic [63:0] i_new_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b1;
    t_status     o_status;
    logic [63:0] o_found_value;
    logic [9:0]  o_entry_position;
    logic [9:0]  o_live_count;

    int  fail_count, pending, full_seen, compactions;
    int  idle_cycles = 0;
    int  sent = 0;
    bit  stimulus_done = 1'b0;
    bit  hold_off = 1'b0;
    logic [63:0] key_pool [64];
    logic [63:0] hash_pool [64];

    always #6 i_clk = ~i_clk;

    compact_hash_map_engine dut (.*);

    compact_hash_map_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_operation,
        .i_key_hash, .i_key, .i_new_value, .i_out_valid(o_out_valid), .i_out_stall,
        .i_status(o_status), .i_found_value(o_found_value),
        .i_entry_position(o_entry_position), .i_live_count(o_live_count),
        .o_fail_count(fail_count), .o_pending(pending), .o_full_seen(full_seen),
        .o_compactions(compactions)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no transaction for %0d cycles", IdleLimit);
            $display("** compact_hash_map_engine: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input t_op op, input logic [63:0] h,
                                input logic [63:0] k, input logic [63:0] v,
                                input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key_hash  <= h;
        i_key       <= k;
        i_new_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int p;
        int r;
        int drain;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 64; k++) begin
            key_pool[k]  = rand64();
            hash_pool[k] = (k < 16) ? ({2'($urandom_range(0, 3)), 62'h0} | 64'(k))
                                    : rand64();
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        hash_pool[0] = '0;
        hash_pool[1] = '1;

        // directed: miss, insert, update, lookup, delete, reinsert, colliding hashes
        send_request(OpLookup, '0, '0, '0);
        send_request(OpDelete, '1, '1, '0);
        send_request(OpInsert, '0, '0, '1);
        send_request(OpInsert, '1, '1, '0);
        send_request(OpInsert, '0, '0, 64'h5555_aaaa_5555_aaaa);
        send_request(OpLookup, '0, '0, '1);
        send_request(OpLookup, '1, '1, '0);
        send_request(t_op'(2'd3), '1, '1, '1);
        send_request(OpInsert, '0, 64'h1234, 64'habcd);
        send_request(OpInsert, 64'h400, 64'h4321, 64'hdcba);
        send_request(OpLookup, 64'h400, 64'h4321, '0);
        send_request(OpDelete, '0, '0, '0);
        send_request(OpDelete, '0, '0, '0);
        send_request(OpLookup, '0, 64'h1234, '0);
        send_request(OpInsert, '0, '0, 64'h77);
        send_request(OpLookup, '1, '0, '0);

        // fill the entry memory with distinct keys to reach compaction and full
        hold_off = 1'b1;
        for (int k = 0; k < EntryCap + 4; k++)
            send_request(OpInsert, rand64(), rand64() | 64'h1, rand64(), k < 60);
        for (int k = 0; k < 8; k++) begin
            send_request(OpInsert, hash_pool[k], key_pool[k], rand64());
            send_request(OpDelete, hash_pool[k], key_pool[k], '0);
        end

        // random part: mostly a small key pool so hits, deletes and reuse dominate
        for (int n = 0; n < RandomItems; n++) begin
            p = $urandom_range(0, 63);
            r = $urandom_range(0, 9);
            if (r < 4)
                send_request(OpInsert, hash_pool[p], key_pool[p], rand64());
            else if (r < 7)
                send_request(OpDelete, hash_pool[p], key_pool[p], '0);
            else if (r < 9)
                send_request(OpLookup, hash_pool[p], key_pool[p], rand64());
            else
                send_request(t_op'($urandom_range(0, 3)), rand64(), rand64(), rand64());
        end
        i_in_valid <= 1'b0;
        stimulus_done = 1'b1;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 200) begin
            @(posedge i_clk);
            drain++;
        end
        $display("sent %0d requests, %0d full responses, %0d compactions predicted",
                 sent, full_seen, compactions);
        if (fail_count == 0)
            $display("** compact_hash_map_engine: PASSED **");
        else
            $display("** compact_hash_map_engine: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/chm_pkg.sv
hw/rtl/compact_hash_map_engine.sv
verif/compact_hash_map_checker.sv
verif/compact_hash_map_engine_tb.sv
